// File: design/sccb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register access master - shared definitions
// Payload structs, sequencer state type, register codes and step helpers.
// ----------------------------------------------------------------------------
package sccb_pkg;

    localparam int SCCB_TIMER_WIDTH = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEVICE_ADDR = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_TICKS   = 2'd2;

    localparam logic [7:0]  DEVICE_ADDR_RESET = 8'd96;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;
    localparam logic [15:0] GAP_TICKS_RESET   = 16'd100;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] BYTE_REGISTER = 2'd1;
    localparam logic [1:0] BYTE_PAYLOAD  = 2'd2;
    localparam logic       OP_WRITE      = 1'b0;

    typedef struct packed {
        logic       request_valid;
        logic       opcode;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_sample;
    } t_sccb_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } t_sccb_out;

    typedef struct packed {
        logic [7:0]  device_write_address;
        logic [15:0] phase_ticks;
        logic [15:0] gap_ticks;
    } t_sccb_cfg;

    typedef struct packed {
        logic idle;
    } t_sccb_status;

    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,
        ST_STA  = 5'd1,
        ST_STB  = 5'd2,
        ST_WLO  = 5'd3,
        ST_WHI  = 5'd4,
        ST_ALO  = 5'd5,
        ST_AHI  = 5'd6,
        ST_GAP  = 5'd7,
        ST_SPA  = 5'd8,
        ST_SPB  = 5'd9,
        ST_SPC  = 5'd10,
        ST_RLO  = 5'd11,
        ST_RHI  = 5'd12,
        ST_NAA  = 5'd13,
        ST_NAB  = 5'd14,
        ST_NAC  = 5'd15,
        ST_NAD  = 5'd16,
        ST_PGAP = 5'd17
    } t_step;

    typedef struct packed {
        t_step      step;
        logic [3:0] bit_cnt;
        logic [1:0] byte_idx;
        logic [7:0] shift;
        logic       held_op;
        logic [7:0] held_reg;
        logic [7:0] held_data;
        logic       err;
        logic [7:0] captured;
        logic       scl;
        logic       sda;
        logic       fin;
    } t_seq_st;

    localparam t_seq_st SEQ_RESET = '{
        step: ST_IDLE, bit_cnt: 4'd0, byte_idx: 2'd0, shift: 8'd0,
        held_op: 1'b0, held_reg: 8'd0, held_data: 8'd0, err: 1'b0,
        captured: 8'd0, scl: 1'b1, sda: 1'b1, fin: 1'b0
    };

    // Picks the next byte to shift out from the byte index.
    function automatic t_seq_st seq_load_byte(t_seq_st st, logic [7:0] dev);
        t_seq_st s;
        s = st;
        if (s.byte_idx == 2'd0) begin
            s.shift = dev;
        end else if (s.byte_idx == BYTE_REGISTER) begin
            s.shift = s.held_reg;
        end else if (s.held_op == OP_WRITE) begin
            s.shift = s.held_data;
        end else begin
            s.shift = dev | 8'h01;
        end
        s.bit_cnt = 4'd0;
        return s;
    endfunction

    // Step that follows the current one once its duration has run out.
    function automatic t_seq_st seq_successor(t_seq_st st, logic [7:0] dev);
        t_seq_st s;
        s = st;
        unique case (st.step)
            ST_STA: s.step = ST_STB;
            ST_STB: begin
                s = seq_load_byte(s, dev);
                s.step = ST_WLO;
            end
            ST_WLO: s.step = ST_WHI;
            ST_WHI: begin
                s.shift   = {s.shift[6:0], 1'b0};
                s.bit_cnt = s.bit_cnt + 4'd1;
                s.step    = (s.bit_cnt >= BITS_PER_BYTE) ? ST_ALO : ST_WLO;
            end
            ST_ALO: s.step = ST_AHI;
            ST_AHI: begin
                s.step = (s.held_op == OP_WRITE && s.byte_idx >= BYTE_PAYLOAD) ?
                         ST_SPA : ST_GAP;
            end
            ST_GAP: begin
                if (s.held_op != OP_WRITE && s.byte_idx == BYTE_REGISTER) begin
                    s.step = ST_SPA;
                end else if (s.held_op != OP_WRITE && s.byte_idx >= BYTE_PAYLOAD) begin
                    s.shift   = 8'd0;
                    s.bit_cnt = 4'd0;
                    s.step    = ST_RLO;
                end else begin
                    s.byte_idx = s.byte_idx + 2'd1;
                    s = seq_load_byte(s, dev);
                    s.step = ST_WLO;
                end
            end
            ST_SPA: s.step = ST_SPB;
            ST_SPB: s.step = ST_SPC;
            ST_SPC: begin
                if (s.held_op != OP_WRITE && s.byte_idx == BYTE_REGISTER) begin
                    s.byte_idx = BYTE_PAYLOAD;
                    s.step     = ST_PGAP;
                end else begin
                    if (s.held_op != OP_WRITE) begin
                        s.captured = s.shift;
                    end
                    s.fin  = 1'b1;
                    s.step = ST_IDLE;
                end
            end
            ST_RLO: s.step = ST_RHI;
            ST_RHI: begin
                s.bit_cnt = s.bit_cnt + 4'd1;
                s.step    = (s.bit_cnt >= BITS_PER_BYTE) ? ST_NAA : ST_RLO;
            end
            ST_NAA:  s.step = ST_NAB;
            ST_NAB:  s.step = ST_NAC;
            ST_NAC:  s.step = ST_NAD;
            ST_NAD:  s.step = ST_SPA;
            ST_PGAP: s.step = ST_STA;
            default: s.step = ST_IDLE;
        endcase
        return s;
    endfunction

    // Line drives set on entry to a step; unlisted lines keep their level.
    function automatic t_seq_st seq_enter(t_seq_st st);
        t_seq_st s;
        s = st;
        unique case (st.step)
            ST_IDLE: begin s.scl = 1'b1; s.sda = 1'b1; end
            ST_STA:  begin s.scl = 1'b1; s.sda = 1'b1; end
            ST_STB:  begin s.scl = 1'b1; s.sda = 1'b0; end
            ST_WLO:  begin s.scl = 1'b0; s.sda = s.shift[7]; end
            ST_WHI:  s.scl = 1'b1;
            ST_ALO:  begin s.scl = 1'b0; s.sda = 1'b1; end
            ST_AHI:  s.scl = 1'b1;
            ST_GAP:  s.scl = 1'b0;
            ST_SPA:  begin s.scl = 1'b0; s.sda = 1'b0; end
            ST_SPB:  s.scl = 1'b1;
            ST_SPC:  s.sda = 1'b1;
            ST_RLO:  begin s.scl = 1'b0; s.sda = 1'b1; end
            ST_RHI:  s.scl = 1'b1;
            ST_NAA:  begin s.scl = 1'b0; s.sda = 1'b1; end
            ST_NAB:  begin s.scl = 1'b1; s.sda = 1'b1; end
            ST_NAC:  s.scl = 1'b0;
            ST_NAD:  s.sda = 1'b0;
            default: ;
        endcase
        return s;
    endfunction

endpackage

// File: design/sccb_register_access_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register access master - top level
// Two-wire register write/read master stepped once per timing tick.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  -------------------------
//  in        sink       i_in_valid / o_in_ready     i_in_data  (t_sccb_in)
//  out       source     o_out_valid / i_out_ready   o_out_data (t_sccb_out)
//  cfg       sink       i_cfg_wr_en (no wait)       i_cfg_index, i_cfg_wdata
//
//  Each input transaction is a timing tick; it produces exactly one result
//  in the next cycle. A tick can be accepted every clock unless stalled: the
//  sequencer step is combinational logic between its state registers and
//  the result register. Reset is synchronous and active low; it returns the
//  sequencer to idle with both lines released and restores register defaults.
//  When the result register is full and not being taken, o_in_ready drops
//  and the sequencer holds; it resumes as soon as the result is drained.
//
//  A write transaction sends start, device address, register number and data
//  byte, each MSB first with an acknowledge sample at the end of the ninth
//  SCL high phase, then stop; a NACK sets the acknowledge error flag. A
//  read sends start, address and register, stop, a gap, then start and the
//  read address, shifts in eight bits (sampled on the first tick of each SCL
//  high phase), answers with a master NACK and ends with stop.
// ----------------------------------------------------------------------------
module sccb_register_access_master #(
    parameter int TIMER_WIDTH = sccb_pkg::SCCB_TIMER_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  sccb_pkg::t_sccb_in                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output sccb_pkg::t_sccb_out                  o_out_data,
    input  logic                                 i_cfg_wr_en,
    input  logic [sccb_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [sccb_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);
    import sccb_pkg::*;

    t_sccb_cfg    cfg;
    t_sccb_out    seq_result;
    t_sccb_status seq_status;
    logic         in_accept;
    logic         can_load;

    // A tick is taken whenever the result register has room for its result.
    assign o_in_ready = can_load;
    assign in_accept  = i_in_valid && can_load;

    sccb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The sequencer only advances on accepted ticks, so stalls never lose
    // or repeat a step.
    sccb_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (in_accept),
        .i_in      (i_in_data),
        .i_cfg     (cfg),
        .o_result  (seq_result),
        .o_status  (seq_status)
    );

    sccb_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_data      (seq_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Every accepted tick leaves a result waiting in the next cycle.
    a_result_follows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid
    ) else $error("accepted tick produced no result");

    // A request taken while idle starts a transaction.
    a_request_starts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept && seq_status.idle && i_in_data.request_valid |=> !seq_status.idle
    ) else $error("request taken while idle did not start a transaction");

    // The finishing tick reports the block as no longer busy.
    a_done_not_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res
    ) else $error("done reported while still busy");

endmodule

// File: design/sccb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB configuration registers
// Holds device address, phase length and gap length, written by index.
// ----------------------------------------------------------------------------
module sccb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sccb_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [sccb_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    output sccb_pkg::t_sccb_cfg                 o_cfg
);
    import sccb_pkg::*;

    t_sccb_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_write_address <= DEVICE_ADDR_RESET;
            r_cfg.phase_ticks          <= PHASE_TICKS_RESET;
            r_cfg.gap_ticks            <= GAP_TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDR: r_cfg.device_write_address <= i_cfg_wdata[7:0];
                CFG_PHASE_TICKS: r_cfg.phase_ticks          <= i_cfg_wdata;
                CFG_GAP_TICKS:   r_cfg.gap_ticks            <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/sccb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB bus sequencer
// Advances the bus sequence by one tick per accepted transaction.
// ----------------------------------------------------------------------------
module sccb_seq #(
    parameter int TIMER_WIDTH = sccb_pkg::SCCB_TIMER_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step_en,
    input  sccb_pkg::t_sccb_in     i_in,
    input  sccb_pkg::t_sccb_cfg    i_cfg,
    output sccb_pkg::t_sccb_out    o_result,
    output sccb_pkg::t_sccb_status o_status
);
    import sccb_pkg::*;

    localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [LW-1:0] CNT_MAX = LW'({TIMER_WIDTH{1'b1}});

    t_seq_st                r_st, n_st, s_pre;
    logic [TIMER_WIDTH-1:0] r_tick, n_tick;

    // Duration of a step, clipped to what the tick counter can reach.
    function automatic logic [LW-1:0] step_len(t_step s, logic [15:0] phase,
                                               logic [15:0] gap);
        logic [LW-1:0] d;
        if (s == ST_GAP || s == ST_PGAP) begin
            d = LW'(gap);
        end else begin
            d = (phase == 16'd0) ? LW'(1) : LW'(phase);
        end
        return (d > CNT_MAX) ? CNT_MAX : d;
    endfunction

    // Next state.
    always_comb begin
        t_seq_st                st;
        logic [TIMER_WIDTH-1:0] tick;
        st     = r_st;
        tick   = r_tick;
        st.fin = 1'b0;
        if (st.step == ST_IDLE && i_in.request_valid) begin
            st.held_op   = i_in.opcode;
            st.held_reg  = i_in.register_address;
            st.held_data = i_in.write_data;
            st.err       = 1'b0;
            st.byte_idx  = 2'd0;
            st.bit_cnt   = 4'd0;
            st.step      = ST_STA;
            st           = seq_enter(st);
            tick         = '0;
        end
        s_pre = st;
        if (st.step != ST_IDLE) begin
            if (st.step == ST_RHI && tick == '0) begin
                st.shift = {st.shift[6:0], i_in.sda_sample};
            end
            tick = tick + TIMER_WIDTH'(1);
            if (LW'(tick) >= step_len(st.step, i_cfg.phase_ticks, i_cfg.gap_ticks)) begin
                if (st.step == ST_AHI && st.held_op == OP_WRITE && i_in.sda_sample) begin
                    st.err = 1'b1;
                end
                st = seq_successor(st, i_cfg.device_write_address);
                st = seq_enter(st);
                // An empty gap passes straight on to the step after it.
                if ((st.step == ST_GAP || st.step == ST_PGAP) &&
                    i_cfg.gap_ticks == 16'd0) begin
                    st = seq_successor(st, i_cfg.device_write_address);
                    st = seq_enter(st);
                end
                tick = '0;
            end
        end
        n_st   = st;
        n_tick = tick;
    end

    // Outputs.
    always_comb begin
        o_result.scl_level = s_pre.scl;
        o_result.sda_level = s_pre.sda;
        o_result.busy_res  = (n_st.step != ST_IDLE);
        o_result.done_res  = n_st.fin;
        o_result.read_data = n_st.captured;
        o_result.ack_error = n_st.err;
        o_status.idle      = (r_st.step == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= SEQ_RESET;
            r_tick <= '0;
        end else if (i_step_en) begin
            r_st   <= n_st;
            r_tick <= n_tick;
        end
    end

endmodule

// File: design/sccb_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module sccb_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sccb_pkg::t_sccb_out i_data,
    input  logic                i_out_ready,
    output logic                o_can_load,
    output logic                o_out_valid,
    output sccb_pkg::t_sccb_out o_out_data
);
    import sccb_pkg::*;

    logic      r_valid;
    t_sccb_out r_data;

    // Loading is allowed when empty or when the held result leaves now.
    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// File: bench/sccb_register_access_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register access master - testbench
// Drives timing ticks into the master, predicts every per-tick output in a
// cycle-level model of the bus sequencer, and compares each result field by
// field. It covers register writes and reads, acknowledge errors and read
// data, zero and extreme phase and gap lengths, and back-pressure on both
// channels.
// ----------------------------------------------------------------------------
module sccb_register_access_master_tb;

    import sccb_pkg::*;

    localparam int          HALF_PERIOD       = 1;
    localparam int          RESET_CYCLES      = 6;
    localparam int          WATCHDOG_LIMIT    = 5000;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam int          DRAIN_LIMIT       = 4000;
    localparam int          MAX_PRINTED       = 20;
    localparam int          RANDOM_SETS       = 5;
    localparam int          TICKS_PER_SET     = 150;
    localparam int          DEFAULT_RUN_TICKS = 160;
    localparam int          GAP_RUN_TICKS     = 100;
    localparam int          LONG_PHASE_TICKS  = 100;
    localparam int unsigned TICK_MASK         = (1 << SCCB_TIMER_WIDTH) - 1;
    localparam logic        OP_READ           = 1'b1;

    // How the testbench answers on SDA while a transaction runs.
    typedef enum {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } t_sda_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    t_sccb_in                   in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    t_sccb_out                  out_data;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

    // Flow control between test tasks and the result sink.
    bit steady_flow  = 1'b0;
    bit hold_request = 1'b0;

    // Bus sequencer model: configuration and state.
    logic [7:0]  cfg_dev;
    logic [15:0] cfg_phase;
    logic [15:0] cfg_gap;
    t_step       bus_step;
    int unsigned bus_ticks;
    logic [3:0]  bus_bits;
    logic [1:0]  bus_byte;
    logic [7:0]  bus_shift;
    logic        bus_op;
    logic [7:0]  bus_reg;
    logic [7:0]  bus_data;
    logic        bus_err;
    logic [7:0]  bus_captured;
    logic        bus_scl;
    logic        bus_sda;
    logic        bus_finished;

    // Predicted outputs of accepted ticks, oldest first.
    t_sccb_out pending_tick_results[$];
    t_sccb_out want_result;

    int unsigned ticks_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned writes_done     = 0;
    int unsigned reads_done      = 0;
    int unsigned nacked_writes   = 0;
    int unsigned settings_used   = 0;
    int unsigned idle_cycles     = 0;

    sccb_register_access_master u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    task automatic reset_bus_model();
        cfg_dev      = DEVICE_ADDR_RESET;
        cfg_phase    = PHASE_TICKS_RESET;
        cfg_gap      = GAP_TICKS_RESET;
        bus_step     = ST_IDLE;
        bus_ticks    = 0;
        bus_bits     = '0;
        bus_byte     = '0;
        bus_shift    = '0;
        bus_op       = OP_WRITE;
        bus_reg      = '0;
        bus_data     = '0;
        bus_err      = 1'b0;
        bus_captured = '0;
        bus_scl      = 1'b1;
        bus_sda      = 1'b1;
        bus_finished = 1'b0;
    endtask

    // Length of a step in ticks. Gaps use gap_ticks, every clock phase uses
    // phase_ticks with zero read as one; both saturate at the timer range.
    function automatic int unsigned step_ticks(t_step s);
        int unsigned d;
        if (s == ST_GAP || s == ST_PGAP) begin
            d = 32'(cfg_gap);
        end else begin
            d = (cfg_phase == 16'd0) ? 32'd1 : 32'(cfg_phase);
        end
        if (d > TICK_MASK) begin
            d = TICK_MASK;
        end
        return d;
    endfunction

    // Byte order: device address, register number, then write data or the
    // read address with its low bit set.
    function automatic void load_shift_byte();
        if (bus_byte == 2'd0) begin
            bus_shift = cfg_dev;
        end else if (bus_byte == BYTE_REGISTER) begin
            bus_shift = bus_reg;
        end else if (bus_op == OP_WRITE) begin
            bus_shift = bus_data;
        end else begin
            bus_shift = cfg_dev | 8'h01;
        end
        bus_bits = 4'd0;
    endfunction

    function automatic t_step next_step(t_step s);
        t_step nxt;
        case (s)
            ST_STA: nxt = ST_STB;
            ST_STB: begin
                load_shift_byte();
                nxt = ST_WLO;
            end
            ST_WLO: nxt = ST_WHI;
            ST_WHI: begin
                bus_shift = {bus_shift[6:0], 1'b0};
                bus_bits  = bus_bits + 4'd1;
                nxt = (bus_bits >= BITS_PER_BYTE) ? ST_ALO : ST_WLO;
            end
            ST_ALO: nxt = ST_AHI;
            ST_AHI: begin
                nxt = (bus_op == OP_WRITE && bus_byte >= BYTE_PAYLOAD) ? ST_SPA : ST_GAP;
            end
            ST_GAP: begin
                if (bus_op == OP_READ && bus_byte == BYTE_REGISTER) begin
                    nxt = ST_SPA;
                end else if (bus_op == OP_READ && bus_byte >= BYTE_PAYLOAD) begin
                    bus_shift = 8'd0;
                    bus_bits  = 4'd0;
                    nxt = ST_RLO;
                end else begin
                    bus_byte = bus_byte + 2'd1;
                    load_shift_byte();
                    nxt = ST_WLO;
                end
            end
            ST_SPA: nxt = ST_SPB;
            ST_SPB: nxt = ST_SPC;
            ST_SPC: begin
                if (bus_op == OP_READ && bus_byte == BYTE_REGISTER) begin
                    // First stop of a read: repeated start follows the gap.
                    bus_byte = BYTE_PAYLOAD;
                    nxt = ST_PGAP;
                end else begin
                    if (bus_op == OP_READ) begin
                        bus_captured = bus_shift;
                    end
                    bus_finished = 1'b1;
                    nxt = ST_IDLE;
                end
            end
            ST_RLO: nxt = ST_RHI;
            ST_RHI: begin
                bus_bits = bus_bits + 4'd1;
                nxt = (bus_bits >= BITS_PER_BYTE) ? ST_NAA : ST_RLO;
            end
            ST_NAA:  nxt = ST_NAB;
            ST_NAB:  nxt = ST_NAC;
            ST_NAC:  nxt = ST_NAD;
            ST_NAD:  nxt = ST_SPA;
            ST_PGAP: nxt = ST_STA;
            default: nxt = ST_IDLE;
        endcase
        return nxt;
    endfunction

    // Entering a step sets the line drives. A gap of zero ticks is passed
    // straight through to the step after it.
    function automatic void enter_step(t_step s);
        t_step cur;
        bit    again;
        cur   = s;
        again = 1'b1;
        while (again) begin
            bus_step  = cur;
            bus_ticks = 0;
            case (cur)
                ST_IDLE: begin bus_scl = 1'b1; bus_sda = 1'b1; end
                ST_STA:  begin bus_scl = 1'b1; bus_sda = 1'b1; end
                ST_STB:  begin bus_scl = 1'b1; bus_sda = 1'b0; end
                ST_WLO:  begin bus_scl = 1'b0; bus_sda = bus_shift[7]; end
                ST_WHI:  bus_scl = 1'b1;
                ST_ALO:  begin bus_scl = 1'b0; bus_sda = 1'b1; end
                ST_AHI:  bus_scl = 1'b1;
                ST_GAP:  bus_scl = 1'b0;
                ST_SPA:  begin bus_scl = 1'b0; bus_sda = 1'b0; end
                ST_SPB:  bus_scl = 1'b1;
                ST_SPC:  bus_sda = 1'b1;
                ST_RLO:  begin bus_scl = 1'b0; bus_sda = 1'b1; end
                ST_RHI:  bus_scl = 1'b1;
                ST_NAA:  begin bus_scl = 1'b0; bus_sda = 1'b1; end
                ST_NAB:  begin bus_scl = 1'b1; bus_sda = 1'b1; end
                ST_NAC:  bus_scl = 1'b0;
                ST_NAD:  bus_sda = 1'b0;
                default: ;
            endcase
            if ((cur == ST_GAP || cur == ST_PGAP) && cfg_gap == 16'd0) begin
                cur = next_step(cur);
            end else begin
                again = 1'b0;
            end
        end
    endfunction

    // Advances the model by one tick and returns the outputs of that tick.
    function automatic t_sccb_out sccb_tick_model(t_sccb_in tick);
        t_sccb_out r;
        bus_finished = 1'b0;
        if (bus_step == ST_IDLE && tick.request_valid) begin
            bus_op   = tick.opcode;
            bus_reg  = tick.register_address;
            bus_data = tick.write_data;
            bus_err  = 1'b0;
            bus_byte = 2'd0;
            bus_bits = 4'd0;
            enter_step(ST_STA);
        end
        r           = '0;
        r.scl_level = bus_scl;
        r.sda_level = bus_sda;
        if (bus_step != ST_IDLE) begin
            // Read bits are taken on the first tick of each SCL high phase.
            if (bus_step == ST_RHI && bus_ticks == 0) begin
                bus_shift = {bus_shift[6:0], tick.sda_sample};
            end
            bus_ticks = (bus_ticks + 1) & TICK_MASK;
            if (bus_ticks >= step_ticks(bus_step)) begin
                // Acknowledge is sampled on the last tick of the ninth high phase.
                if (bus_step == ST_AHI && bus_op == OP_WRITE && tick.sda_sample) begin
                    bus_err = 1'b1;
                end
                enter_step(next_step(bus_step));
            end
        end
        r.busy_res  = (bus_step != ST_IDLE);
        r.done_res  = bus_finished;
        r.read_data = bus_captured;
        r.ack_error = bus_err;
        if (bus_finished) begin
            if (bus_op == OP_WRITE) begin
                writes_done++;
                if (bus_err) begin
                    nacked_writes++;
                end
            end else begin
                reads_done++;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, msg);
        end
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Each result transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_tick_results.size() == 0) begin
                report_mismatch("result arrived with no tick pending");
            end else begin
                want_result = pending_tick_results.pop_front();
                check_field("scl_level", 32'(out_data.scl_level),
                            32'(want_result.scl_level));
                check_field("sda_level", 32'(out_data.sda_level),
                            32'(want_result.sda_level));
                check_field("busy_res", 32'(out_data.busy_res),
                            32'(want_result.busy_res));
                check_field("done_res", 32'(out_data.done_res),
                            32'(want_result.done_res));
                check_field("read_data", 32'(out_data.read_data),
                            32'(want_result.read_data));
                check_field("ack_error", 32'(out_data.ack_error),
                            32'(want_result.ack_error));
            end
            results_checked++;
        end
    end

    // The run ends if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_pause_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // Result sink. A hold request from a test task keeps ready low for a long
    // stretch so the result register fills and the input side stalls.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!steady_flow && $urandom_range(0, 99) < 12) begin
                out_ready <= 1'b0;
                stall_left = pick_pause_len() - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one tick, waits for it to be taken, records its prediction and
    // then maybe leaves a random pause before the caller offers the next.
    task automatic send_tick(t_sccb_in tick);
        int unsigned pause;
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        pending_tick_results.push_back(sccb_tick_model(tick));
        ticks_sent++;
        pause = (!steady_flow && $urandom_range(0, 99) < 30) ? pick_pause_len() : 0;
        if (pause > 0) begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    // A tick with random request fields; the SDA level follows the mode.
    function automatic t_sccb_in random_tick(t_sda_mode mode);
        t_sccb_in t;
        t.request_valid    = 1'($urandom_range(0, 1));
        t.opcode           = 1'($urandom_range(0, 1));
        t.register_address = 8'($urandom_range(0, 255));
        t.write_data       = 8'($urandom_range(0, 255));
        case (mode)
            SDA_LOW:  t.sda_sample = 1'b0;
            SDA_HIGH: t.sda_sample = 1'b1;
            default:  t.sda_sample = 1'($urandom_range(0, 1));
        endcase
        return t;
    endfunction

    task automatic idle_ticks(int unsigned count);
        t_sccb_in t;
        repeat (count) begin
            t = random_tick(SDA_RANDOM);
            t.request_valid = 1'b0;
            send_tick(t);
        end
    endtask

    // One request tick, then ticks until the sequencer is idle again. Ticks
    // sent while busy carry random requests, which the block must ignore.
    task automatic run_transaction(logic op, logic [7:0] reg_num, logic [7:0] data,
                                   t_sda_mode mode);
        t_sccb_in t;
        t = random_tick(mode);
        t.request_valid    = 1'b1;
        t.opcode           = op;
        t.register_address = reg_num;
        t.write_data       = data;
        send_tick(t);
        while (bus_step != ST_IDLE) begin
            send_tick(random_tick(mode));
        end
    endtask

    // Lets every result drain so the block is quiet before a register write.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_tick_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DEVICE_ADDR: cfg_dev   = value[7:0];
            CFG_PHASE_TICKS: cfg_phase = value;
            CFG_GAP_TICKS:   cfg_gap   = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [7:0] dev, logic [15:0] phase, logic [15:0] gap);
        settle_block();
        write_reg(CFG_DEVICE_ADDR, {8'd0, dev});
        write_reg(CFG_PHASE_TICKS, phase);
        write_reg(CFG_GAP_TICKS, gap);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // A write started with the register defaults left by reset. The default
    // phase is long, so once the start condition has run and the first data
    // bit is in its high phase, the phase is shortened and the write finishes.
    task automatic test_reset_defaults();
        t_sccb_in t;
        idle_ticks(5);
        t = random_tick(SDA_RANDOM);
        t.request_valid = 1'b1;
        t.opcode        = OP_WRITE;
        send_tick(t);
        repeat (DEFAULT_RUN_TICKS) send_tick(random_tick(SDA_RANDOM));
        apply_settings(DEVICE_ADDR_RESET, 16'd1, 16'd0);
        while (bus_step != ST_IDLE) begin
            send_tick(random_tick(SDA_RANDOM));
        end
        idle_ticks(3);
    endtask

    // Field extremes, both operations, NACK and error clearing, zero-length
    // phases and gaps, odd and extreme device addresses.
    task automatic test_directed_cases();
        // Odd address for the read address, zero phase counts as one tick,
        // zero gaps are skipped entirely.
        apply_settings(8'hFF, 16'd0, 16'd0);
        run_transaction(OP_WRITE, 8'h00, 8'h00, SDA_LOW);
        run_transaction(OP_WRITE, 8'hFF, 8'hFF, SDA_HIGH);
        run_transaction(OP_READ, 8'hFF, 8'h00, SDA_HIGH);
        run_transaction(OP_READ, 8'h00, 8'hFF, SDA_LOW);
        apply_settings(8'h00, 16'd1, 16'd1);
        run_transaction(OP_WRITE, 8'hA5, 8'h5A, SDA_HIGH);
        idle_ticks(4);
        // A read clears the error left by the failed write and never sets it.
        run_transaction(OP_READ, 8'h3C, 8'h00, SDA_HIGH);
        run_transaction(OP_WRITE, 8'h81, 8'h7E, SDA_LOW);
        apply_settings(8'hFE, 16'd1, 16'd0);
        run_transaction(OP_READ, 8'h55, 8'hAA, SDA_RANDOM);
    endtask

    // Long result hold-off with the sender still offering, then a sender
    // pause in the middle of a transaction until all results are back.
    task automatic test_flow_control();
        t_sccb_in t;
        apply_settings(8'h30, 16'd1, 16'd2);
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        run_transaction(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        SDA_RANDOM);
        steady_flow  = 1'b0;
        t = random_tick(SDA_RANDOM);
        t.request_valid = 1'b1;
        t.opcode        = OP_WRITE;
        send_tick(t);
        repeat (25) send_tick(random_tick(SDA_RANDOM));
        in_valid <= 1'b0;
        while (pending_tick_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        while (bus_step != ST_IDLE) begin
            send_tick(random_tick(SDA_RANDOM));
        end
    endtask

    // Random transactions under several settings, with short idle stretches
    // between them and steady runs without any idling now and then.
    task automatic test_random_traffic();
        int unsigned start;
        int unsigned pick;
        t_sda_mode   mode;
        for (int set = 0; set < RANDOM_SETS; set++) begin
            case (set)
                0: apply_settings(8'($urandom_range(0, 255)) & 8'hFE, 16'd1, 16'd0);
                1: apply_settings(8'($urandom_range(0, 255)), 16'd2, 16'd1);
                2: apply_settings(8'd254, 16'd1, 16'd3);
                default: apply_settings(8'($urandom_range(0, 255)),
                                        16'($urandom_range(1, 3)),
                                        16'($urandom_range(0, 3)));
            endcase
            start = ticks_sent;
            while (ticks_sent - start < TICKS_PER_SET) begin
                steady_flow = ($urandom_range(0, 9) < 2);
                pick = $urandom_range(0, 3);
                mode = (pick == 0) ? SDA_LOW : (pick == 1) ? SDA_HIGH : SDA_RANDOM;
                if ($urandom_range(0, 9) < 8) begin
                    run_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), mode);
                end else begin
                    idle_ticks($urandom_range(1, 6));
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    // Largest gap: a write runs into its first inter-byte gap and waits there
    // for a while, then the gap is shortened so the write can finish.
    task automatic test_long_gap();
        t_sccb_in t;
        apply_settings(8'h42, 16'd1, 16'hFFFF);
        steady_flow = 1'b1;
        t = random_tick(SDA_LOW);
        t.request_valid = 1'b1;
        t.opcode        = OP_WRITE;
        send_tick(t);
        while (bus_step != ST_GAP) begin
            send_tick(random_tick(SDA_LOW));
        end
        repeat (GAP_RUN_TICKS) send_tick(random_tick(SDA_LOW));
        steady_flow = 1'b0;
        apply_settings(8'h42, 16'd1, 16'd2);
        while (bus_step != ST_IDLE) begin
            send_tick(random_tick(SDA_LOW));
        end
    endtask

    // Largest phase: the start phase is only partly run, so this comes last.
    task automatic test_long_phase();
        t_sccb_in t;
        apply_settings(8'h60, 16'hFFFF, 16'd0);
        t = random_tick(SDA_RANDOM);
        t.request_valid = 1'b1;
        send_tick(t);
        repeat (LONG_PHASE_TICKS) send_tick(random_tick(SDA_RANDOM));
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial begin
        reset_bus_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_flow_control();
        test_random_traffic();
        test_long_gap();
        test_long_phase();

        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && pending_tick_results.size() != 0; i++) begin
            @(posedge i_clk);
        end
        if (pending_tick_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_tick_results.size()));
        end
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d ticks under %0d register settings, %0d results checked.",
                 ticks_sent, settings_used + 1, results_checked);
        $display("Bus traffic: %0d register writes (%0d with NACK), %0d register reads.",
                 writes_done, nacked_writes, reads_done);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
